/* sv/ips_pkg.sv */
// Shared types, codes and helper functions for the irrigation pump sequencer.
// Depends on nothing; every other file of the block imports it.
package ips_pkg;

  // Field widths
  localparam int REQ_W      = 2;
  localparam int DUR_W      = 16;
  localparam int PCT_W      = 7;
  localparam int BEEP_W     = 2;
  localparam int HOLD_W     = 3;
  localparam int TIMER_BITS = 16;
  localparam int CMP_W      = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_DUR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_LOW   = 3'd5;

  // Command codes (poll and the unused code fall through as no command)
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

  // Beep event codes
  localparam logic [BEEP_W-1:0] BEEP_NONE  = 2'd0;
  localparam logic [BEEP_W-1:0] BEEP_AUTO  = 2'd1;
  localparam logic [BEEP_W-1:0] BEEP_DRY   = 2'd2;
  localparam logic [BEEP_W-1:0] BEEP_ABORT = 2'd3;

  localparam logic [HOLD_W-1:0] ALERT_HOLDOFF_S = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_IRR  = 2'd1,
    PH_COOL = 2'd2
  } phase_t;

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef struct packed {
    logic              auto_mode;
    logic [PCT_W-1:0]  dry_level;
    logic [DUR_W-1:0]  auto_duration_s;
    logic [DUR_W-1:0]  max_pump_on_s;
    logic [DUR_W-1:0]  cooldown_s;
    logic              relay_invert;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [DUR_W-1:0]  manual_duration_s;
    logic              second_tick;
    logic [PCT_W-1:0]  moisture;
    logic              water_present;
  } item_t;

  typedef struct packed {
    logic [1:0]        phase_now;
    logic              pump_on;
    logic              relay_level;
    logic [BEEP_W-1:0] beep_event;
    logic [PCT_W-1:0]  soil_before;
  } result_t;

  typedef struct packed {
    phase_t            phase;
    logic              pump;
    timer_t            run_seconds;
    logic [DUR_W-1:0]  run_limit;
    timer_t            cool_seconds;
    logic [PCT_W-1:0]  soil_start;
    logic [HOLD_W-1:0] alert_holdoff;
  } state_t;

  // Saturating timer increment
  function automatic timer_t sat_inc(input timer_t v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  // Timer reached a 16-bit limit
  function automatic logic timer_ge(input timer_t t, input logic [DUR_W-1:0] lim);
    timer_ge = CMP_W'(t) >= CMP_W'(lim);
  endfunction

endpackage

/* sv/ips_if.sv */
// Valid/ready channel interfaces for sequencer commands and results.
// Depends on ips_pkg for the field widths.
interface ips_req_if;
  import ips_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [DUR_W-1:0] manual_duration_s;
  logic             second_tick;
  logic [PCT_W-1:0] moisture;
  logic             water_present;

  modport source (output valid, req_type, manual_duration_s, second_tick, moisture,
                  water_present, input ready);
  modport sink   (input valid, req_type, manual_duration_s, second_tick, moisture,
                  water_present, output ready);
endinterface

interface ips_res_if;
  import ips_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        phase_now;
  logic              pump_on;
  logic              relay_level;
  logic [BEEP_W-1:0] beep_event;
  logic [PCT_W-1:0]  soil_before;

  modport source (output valid, phase_now, pump_on, relay_level, beep_event,
                  soil_before, input ready);
  modport sink   (input valid, phase_now, pump_on, relay_level, beep_event,
                  soil_before, output ready);
endinterface

/* sv/irrigation_pump_sequencer.sv */
// Top level of the irrigation pump sequencer: input register, step, result register.
// Depends on ips_pkg, ips_if, ips_cfg_regs and ips_step.
//
// Usage:
//   req carries one beat per sensor/command event: req_type, manual_duration_s,
//   second_tick, moisture and water_present. res returns exactly one beat per
//   request: phase_now, pump_on, relay_level, beep_event and soil_before.
//   Both channels move a beat at a rising edge where valid and ready are high.
//   The cfg_we/cfg_index/cfg_wdata port writes the six settings registers;
//   write them only while no request is in flight.
// Timing:
//   A request accepted into the input register is stepped into the result register
//   once that register is free or draining, and is taken from res from there.
//   The input register and the result register keep one beat each, and the
//   step logic is combinational over the whole sequencer state, so one beat
//   per cycle is sustained while res.ready stays high.
// Reset (rst, synchronous): sequencer idle, pump off, timers and captured
//   moisture zero, settings at their defaults, both registers empty.
// Stall: while res.ready is low the result holds; one more request is
//   taken into the input register, then req.ready drops until res drains.
module irrigation_pump_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ips_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ips_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ips_req_if.sink                         req,
  ips_res_if.source                       res
);
  import ips_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   in_item;
  logic    in_valid;
  result_t out_res;
  result_t res_next;
  logic    out_valid;
  logic    advance;

  ips_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ips_step u_step (
    .state      (state),
    .item       (in_item),
    .cfg        (cfg),
    .state_next (state_next),
    .res_next   (res_next)
  );

  // Step the held beat whenever the result register is free or draining
  assign advance   = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      in_item.req_type          <= req.req_type;
      in_item.manual_duration_s <= req.manual_duration_s;
      in_item.second_tick       <= req.second_tick;
      in_item.moisture          <= req.moisture;
      in_item.water_present     <= req.water_present;
    end
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (advance)
      out_res <= res_next;
  end

  assign res.valid       = out_valid;
  assign res.phase_now   = out_res.phase_now;
  assign res.pump_on     = out_res.pump_on;
  assign res.relay_level = out_res.relay_level;
  assign res.beep_event  = out_res.beep_event;
  assign res.soil_before = out_res.soil_before;

endmodule

/* sv/ips_cfg_regs.sv */
// Configuration register bank of the pump sequencer, written by index.
// Depends on ips_pkg for the register map and cfg_t.
module ips_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ips_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ips_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output ips_pkg::cfg_t                   cfg
);
  import ips_pkg::*;

  // Load reset defaults, then take writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_mode       <= 1'b1;
      cfg.dry_level       <= PCT_W'(30);
      cfg.auto_duration_s <= DUR_W'(10);
      cfg.max_pump_on_s   <= DUR_W'(60);
      cfg.cooldown_s      <= DUR_W'(30);
      cfg.relay_invert    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO_MODE: cfg.auto_mode       <= cfg_wdata[0];
        CFG_THRESHOLD: cfg.dry_level       <= cfg_wdata[PCT_W-1:0];
        CFG_AUTO_DUR:  cfg.auto_duration_s <= cfg_wdata[DUR_W-1:0];
        CFG_MAX_ON:    cfg.max_pump_on_s   <= cfg_wdata[DUR_W-1:0];
        CFG_COOLDOWN:  cfg.cooldown_s      <= cfg_wdata[DUR_W-1:0];
        CFG_RELAY_LOW: cfg.relay_invert    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/ips_step.sv */
// Single-item step of the pump sequencer: command, hold-off, then phase step.
// Depends on ips_pkg for state, item, result and configuration types.
module ips_step (
  input  ips_pkg::state_t  state,
  input  ips_pkg::item_t   item,
  input  ips_pkg::cfg_t    cfg,
  output ips_pkg::state_t  state_next,
  output ips_pkg::result_t res_next
);
  import ips_pkg::*;

  state_t            s;
  logic              fresh;
  logic [BEEP_W-1:0] beep;

  always_comb begin
    s     = state;
    fresh = 1'b0;
    beep  = BEEP_NONE;

    // Apply the command first
    if (item.req_type == REQ_START && (s.phase == PH_IDLE || s.phase == PH_COOL)) begin
      s.phase       = PH_IRR;
      s.run_limit   = item.manual_duration_s;
      s.run_seconds = '0;
      s.soil_start  = item.moisture;
      fresh         = 1'b1;
    end else if (item.req_type == REQ_STOP && s.phase == PH_IRR) begin
      s.phase        = PH_COOL;
      s.cool_seconds = '0;
      fresh          = 1'b1;
    end

    // Count down the no-water hold-off in any phase
    if (item.second_tick && s.alert_holdoff != '0)
      s.alert_holdoff = s.alert_holdoff - 1'b1;

    // One phase step
    unique case (s.phase)
      PH_IDLE: begin
        s.pump = 1'b0;
        if (cfg.auto_mode && s.alert_holdoff == '0 &&
            item.moisture < cfg.dry_level) begin
          if (item.water_present) begin
            s.phase       = PH_IRR;
            s.run_limit   = cfg.auto_duration_s;
            s.run_seconds = '0;
            s.soil_start  = item.moisture;
            beep          = BEEP_AUTO;
          end else begin
            beep            = BEEP_DRY;
            s.alert_holdoff = ALERT_HOLDOFF_S;
          end
        end
      end
      PH_IRR: begin
        if (!item.water_present) begin
          // Abort: pump level is left as is until the next cooldown step
          s.phase        = PH_COOL;
          s.cool_seconds = '0;
          beep           = BEEP_ABORT;
        end else begin
          s.pump = 1'b1;
          if (item.second_tick && !fresh)
            s.run_seconds = sat_inc(s.run_seconds);
          if (timer_ge(s.run_seconds, s.run_limit) ||
              timer_ge(s.run_seconds, cfg.max_pump_on_s)) begin
            s.phase        = PH_COOL;
            s.cool_seconds = '0;
          end
        end
      end
      default: begin
        s.pump = 1'b0;
        if (item.second_tick && !fresh)
          s.cool_seconds = sat_inc(s.cool_seconds);
        if (timer_ge(s.cool_seconds, cfg.cooldown_s))
          s.phase = PH_IDLE;
      end
    endcase

    state_next           = s;
    res_next.phase_now   = s.phase;
    res_next.pump_on     = s.pump;
    res_next.relay_level = s.pump ^ cfg.relay_invert;
    res_next.beep_event  = beep;
    res_next.soil_before = s.soil_start;
  end

endmodule

/* sv/ips_checker.sv */
// Port-level checks on the pump sequencer results, bound to the top level.
// Depends on ips_pkg for phase and beep codes.
module ips_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [1:0]                  phase_now,
  input logic                        pump_on,
  input logic [ips_pkg::BEEP_W-1:0]  beep_event
);
  import ips_pkg::*;

  // Hold a stalled result beat
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  // Idle never drives the pump
  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    res_valid && phase_now == PH_IDLE |-> !pump_on)
    else $error("pump on in idle");

  // Auto start lands in irrigating with pump not yet on
  a_auto_irr: assert property (@(posedge clk) disable iff (rst)
    res_valid && beep_event == BEEP_AUTO |-> phase_now == PH_IRR && !pump_on)
    else $error("auto start beat outside irrigating");

  // Abort always leaves the run for cooldown
  a_abort_cool: assert property (@(posedge clk) disable iff (rst)
    res_valid && beep_event == BEEP_ABORT |-> phase_now == PH_COOL)
    else $error("low-water abort without cooldown");

  // No-water alert only from idle
  a_dry_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && beep_event == BEEP_DRY |-> phase_now == PH_IDLE && !pump_on)
    else $error("no-water alert outside idle");

endmodule

bind irrigation_pump_sequencer ips_checker u_ips_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .phase_now  (res.phase_now),
  .pump_on    (res.pump_on),
  .beep_event (res.beep_event)
);

/* verif/testbench.sv */
// Self-checking bench for the irrigation pump sequencer: drives command beats,
// predicts every result beat and compares it field by field.
// Depends on ips_pkg, the ips_req_if/ips_res_if interfaces and the sequencer RTL.
module testbench;
  import ips_pkg::*;

  // Command codes the package leaves unnamed
  localparam logic [REQ_W-1:0] REQ_POLL  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_GAP     = 14;
  localparam int MAX_REPORTS = 10;

  // Predicts the sequencer and keeps the results still owed by it
  class pump_outcome_book;
    cfg_t              settings;
    phase_t            phase;
    logic              pump;
    logic [15:0]       run_seconds;
    logic [DUR_W-1:0]  run_limit;
    logic [15:0]       cool_seconds;
    logic [PCT_W-1:0]  soil_start;
    logic [HOLD_W-1:0] holdoff;
    result_t           due_outcomes[$];
    int                faults;

    function new();
      settings = '{1'b1, 7'd30, 16'd10, 16'd60, 16'd30, 1'b1};
      phase = PH_IDLE;
      pump = 1'b0;
      run_seconds = '0;
      run_limit = '0;
      cool_seconds = '0;
      soil_start = '0;
      holdoff = '0;
      faults = 0;
    endfunction

    function int pending();
      return due_outcomes.size();
    endfunction

    function void write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_AUTO_MODE: settings.auto_mode = data[0];
        CFG_THRESHOLD: settings.dry_level = data[PCT_W-1:0];
        CFG_AUTO_DUR:  settings.auto_duration_s = data;
        CFG_MAX_ON:    settings.max_pump_on_s = data;
        CFG_COOLDOWN:  settings.cooldown_s = data;
        CFG_RELAY_LOW: settings.relay_invert = data[0];
        default: ;
      endcase
    endfunction

    // Count one second, holding at the top of the timer range
    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Apply the command, then one state step, and queue the result it gives
    function void note_request(item_t it);
      logic              fresh;
      logic [BEEP_W-1:0] beep;
      result_t           r;
      fresh = 1'b0;
      beep = BEEP_NONE;

      if (it.req_type == REQ_START && (phase == PH_IDLE || phase == PH_COOL)) begin
        phase = PH_IRR;
        run_limit = it.manual_duration_s;
        run_seconds = '0;
        soil_start = it.moisture;
        fresh = 1'b1;
      end else if (it.req_type == REQ_STOP && phase == PH_IRR) begin
        phase = PH_COOL;
        cool_seconds = '0;
        fresh = 1'b1;
      end

      if (it.second_tick && holdoff != '0)
        holdoff = holdoff - 1'b1;

      case (phase)
        PH_IDLE: begin
          pump = 1'b0;
          if (settings.auto_mode && holdoff == '0 &&
              it.moisture < settings.dry_level) begin
            if (it.water_present) begin
              phase = PH_IRR;
              run_limit = settings.auto_duration_s;
              run_seconds = '0;
              soil_start = it.moisture;
              beep = BEEP_AUTO;
            end else begin
              beep = BEEP_DRY;
              holdoff = ALERT_HOLDOFF_S;
            end
          end
        end
        PH_IRR: begin
          if (!it.water_present) begin
            // pump level holds for this beat
            phase = PH_COOL;
            cool_seconds = '0;
            beep = BEEP_ABORT;
          end else begin
            pump = 1'b1;
            if (it.second_tick && !fresh)
              run_seconds = bump(run_seconds);
            if (run_seconds >= run_limit || run_seconds >= settings.max_pump_on_s) begin
              phase = PH_COOL;
              cool_seconds = '0;
            end
          end
        end
        default: begin
          pump = 1'b0;
          if (it.second_tick && !fresh)
            cool_seconds = bump(cool_seconds);
          if (cool_seconds >= settings.cooldown_s)
            phase = PH_IDLE;
        end
      endcase

      r.phase_now = phase;
      r.pump_on = pump;
      r.relay_level = pump ^ settings.relay_invert;
      r.beep_event = beep;
      r.soil_before = soil_start;
      due_outcomes.push_back(r);
    endfunction

    // Compare a result beat with the oldest prediction
    function void check_outcome(result_t got);
      result_t want;
      if (due_outcomes.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("unexpected result beat: phase=%0d pump=%0d relay=%0d beep=%0d soil=%0d",
                   got.phase_now, got.pump_on, got.relay_level, got.beep_event,
                   got.soil_before);
        return;
      end
      want = due_outcomes.pop_front();
      if (got !== want) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("result mismatch at %0t: expected phase=%0d pump=%0d relay=%0d ",
                   $time, want.phase_now, want.pump_on, want.relay_level,
                   "beep=%0d soil=%0d, got phase=%0d pump=%0d relay=%0d ",
                   want.beep_event, want.soil_before, got.phase_now, got.pump_on,
                   got.relay_level, "beep=%0d soil=%0d", got.beep_event,
                   got.soil_before);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ips_req_if req_ch();
  ips_res_if res_ch();

  irrigation_pump_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  pump_outcome_book sb;
  bit               no_gaps;
  int               stall_left;
  int               cycle_count;

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[irrigation_pump_sequencer] ERROR");
      $finish;
    end
  end

  // Result side: hold ready low for the drawn stall, then raise it
  initial begin
    res_ch.ready = 1'b0;
    stall_left = 0;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    result_t got;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.phase_now = res_ch.phase_now;
      got.pump_on = res_ch.pump_on;
      got.relay_level = res_ch.relay_level;
      got.beep_event = res_ch.beep_event;
      got.soil_before = res_ch.soil_before;
      sb.check_outcome(got);
      stall_left = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  function automatic item_t mk(logic [REQ_W-1:0] kind, logic [DUR_W-1:0] dur,
                               logic tick, logic [PCT_W-1:0] moist, logic water);
    item_t it;
    it.req_type = kind;
    it.manual_duration_s = dur;
    it.second_tick = tick;
    it.moisture = moist;
    it.water_present = water;
    return it;
  endfunction

  // Mostly polls with short manual runs; stops, spare codes and dry spells mixed in
  function automatic item_t random_request();
    int               pick;
    logic [REQ_W-1:0] kind;
    logic [DUR_W-1:0] dur;
    pick = $urandom_range(0, 99);
    if (pick < 70)      kind = REQ_POLL;
    else if (pick < 84) kind = REQ_START;
    else if (pick < 96) kind = REQ_STOP;
    else                kind = REQ_SPARE;
    dur = ($urandom_range(0, 99) < 85) ? DUR_W'($urandom_range(0, 8))
                                       : DUR_W'($urandom_range(0, 65535));
    return mk(kind, dur, 1'($urandom_range(0, 1)), PCT_W'($urandom_range(0, 100)),
              $urandom_range(0, 99) >= 8);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.auto_mode = 1'($urandom_range(0, 1));
    s.dry_level = PCT_W'($urandom_range(0, 100));
    s.auto_duration_s = DUR_W'($urandom_range(0, 6));
    s.max_pump_on_s = DUR_W'($urandom_range(0, 8));
    s.cooldown_s = DUR_W'($urandom_range(0, 5));
    s.relay_invert = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Offer one command beat after a drawn gap and wait for it to be taken
  task automatic send_item(input item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= it.req_type;
    req_ch.manual_duration_s <= it.manual_duration_s;
    req_ch.second_tick <= it.second_tick;
    req_ch.moisture <= it.moisture;
    req_ch.water_present <= it.water_present;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(it);
  endtask

  // Drop valid and wait for every owed result, plus the pipeline depth
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_setting(idx, data);
  endtask

  // Load a setting (optionally) and run a stretch of random commands
  task automatic run_phase(input bit load, input cfg_t s, input int count, input bit quiet);
    settle();
    if (load) begin
      set_reg(CFG_AUTO_MODE, CFG_DATA_W'(s.auto_mode));
      set_reg(CFG_THRESHOLD, CFG_DATA_W'(s.dry_level));
      set_reg(CFG_AUTO_DUR, s.auto_duration_s);
      set_reg(CFG_MAX_ON, s.max_pump_on_s);
      set_reg(CFG_COOLDOWN, s.cooldown_s);
      set_reg(CFG_RELAY_LOW, CFG_DATA_W'(s.relay_invert));
      @(negedge clk);
      cfg_we <= 1'b0;
    end
    no_gaps = quiet;
    for (int n = 0; n < count; n++)
      send_item(random_request());
  endtask

  initial begin
    sb = new();
    no_gaps = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_POLL;
    req_ch.manual_duration_s = '0;
    req_ch.second_tick = 1'b0;
    req_ch.moisture = '0;
    req_ch.water_present = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults first
    run_phase(1'b0, '0, 150, 1'b0);

    // Directed: alert and hold-off, auto run, ignored commands, zero-length
    // manual run, restart from cooldown, low-water abort, same-beat stop
    run_phase(1'b1, '{1'b1, 7'd50, 16'd2, 16'd3, 16'd2, 1'b0}, 0, 1'b0);
    send_item(mk(REQ_POLL, 16'd0, 1'b0, 7'd100, 1'b1));
    send_item(mk(REQ_POLL, 16'hFFFF, 1'b0, 7'd10, 1'b0));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd10, 1'b1));
    send_item(mk(REQ_SPARE, 16'd0, 1'b1, 7'd10, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd10, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd10, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd10, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd60, 1'b1));
    send_item(mk(REQ_START, 16'd5, 1'b1, 7'd60, 1'b1));
    send_item(mk(REQ_STOP, 16'd0, 1'b1, 7'd60, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd60, 1'b1));
    send_item(mk(REQ_START, 16'd0, 1'b1, 7'd0, 1'b1));
    send_item(mk(REQ_START, 16'hFFFF, 1'b1, 7'd100, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd100, 1'b0));
    send_item(mk(REQ_POLL, 16'd0, 1'b0, 7'd100, 1'b1));
    send_item(mk(REQ_STOP, 16'd0, 1'b1, 7'd100, 1'b1));
    send_item(mk(REQ_START, 16'd40, 1'b1, 7'd63, 1'b1));
    send_item(mk(REQ_STOP, 16'd0, 1'b1, 7'd63, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd63, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd63, 1'b1));
    send_item(mk(REQ_STOP, 16'd0, 1'b0, 7'd63, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b0, 7'd49, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd49, 1'b1));
    send_item(mk(REQ_POLL, 16'd0, 1'b1, 7'd49, 1'b1));

    // Random stretches across settings, extremes included
    run_phase(1'b1, '{1'b1, 7'd50, 16'd3, 16'd5, 16'd2, 1'b0}, 200, 1'b0);
    run_phase(1'b1, '{1'b1, 7'd100, 16'd0, 16'hFFFF, 16'd0, 1'b1}, 150, 1'b1);
    run_phase(1'b1, '{1'b0, 7'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0}, 80, 1'b0);
    run_phase(1'b1, '{1'b1, 7'd0, 16'd4, 16'd2, 16'd3, 1'b1}, 150, 1'b0);
    run_phase(1'b1, '{1'b1, 7'd100, 16'hFFFF, 16'd6, 16'd1, 1'b0}, 150, 1'b1);
    run_phase(1'b1, random_settings(), 100, 1'b0);
    run_phase(1'b1, random_settings(), 100, 1'b1);
    run_phase(1'b1, random_settings(), 100, 1'b0);

    // Drain and let any stray beat show up
    settle();
    repeat (8) @(posedge clk);
    if (sb.faults == 0 && sb.pending() == 0)
      $display("[irrigation_pump_sequencer] OK");
    else
      $display("[irrigation_pump_sequencer] ERROR");
    $finish;
  end

endmodule
